// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// Clocked concurrent assertions, with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is low
`define FCM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// assertion that is also checked while reset is low
`define FCM_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- rtl/fcm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcm_pkg
// Types, widths and codes shared by the checkpoint monitor modules.
// ---------------------------------------------------------------------------
package fcm_pkg;

  // slot table size
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_CW   = $clog2(NUM_SLOTS + 1);

  // field widths
  localparam int OP_W   = 2;
  localparam int ID_W   = 4;
  localparam int SIG_W  = 32;
  localparam int TS_W   = 64;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 32;

  // request and result queues
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  // operation codes
  localparam op_t OP_REGISTER = 2'd0;
  localparam op_t OP_ENTRY    = 2'd1;
  localparam op_t OP_EXIT     = 2'd2;
  localparam op_t OP_CHECK    = 2'd3;

  // status codes
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_UNREG = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] id;
    logic            in_range;
    logic [SIG_W-1:0] sig;
    logic [TS_W-1:0] ts;
  } cmd_t;

  // one result
  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  assigned_id;
    logic             check_passed;
    logic             failed_flag;
    logic [CNT_W-1:0] call_count;
    logic [TS_W-1:0]  last_ticks;
    logic [TS_W-1:0]  max_ticks;
    logic [SIG_W-1:0] balance;
  } res_t;

endpackage

// ----- rtl/flow_checkpoint_monitor.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flow_checkpoint_monitor
// Program flow and timing monitor with a signature accumulator.
//
//   channel  | handshake          | ports
//   ---------+--------------------+----------------------------------------
//   request  | push / full        | in_opcode in_checkpoint_id in_signature
//            |                    | in_timestamp
//   result   | empty / pop        | out_status out_assigned_id ... out_balance
//
// Each request passes through the execute sequencer steps take, slot table
// read, elapsed time and count, and commit; one request is in execution at a time.
// A two-entry request queue and a two-entry result queue decouple the sides.
// The sequencer waits while the result queue is full.
// Reset clears both queues, the slot valid bits, the slot count, the
// accumulator and the failure flag; it takes effect on the next edge.
// ---------------------------------------------------------------------------
module flow_checkpoint_monitor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [fcm_pkg::OP_W-1:0]    in_opcode,
  input  logic [fcm_pkg::ID_W-1:0]    in_checkpoint_id,
  input  logic [fcm_pkg::SIG_W-1:0]   in_signature,
  input  logic [fcm_pkg::TS_W-1:0]    in_timestamp,
  output logic                        empty,
  input  logic                        pop,
  output logic [fcm_pkg::STAT_W-1:0]  out_status,
  output logic [fcm_pkg::ID_W-1:0]    out_assigned_id,
  output logic                        out_check_passed,
  output logic                        out_failed_flag,
  output logic [fcm_pkg::CNT_W-1:0]   out_call_count,
  output logic [fcm_pkg::TS_W-1:0]    out_last_ticks,
  output logic [fcm_pkg::TS_W-1:0]    out_max_ticks,
  output logic [fcm_pkg::SIG_W-1:0]   out_balance
);
  import fcm_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  // request intake and classification
  fcm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_checkpoint_id (in_checkpoint_id),
    .in_signature     (in_signature),
    .in_timestamp     (in_timestamp),
    .cmd_valid        (cmd_valid),
    .cmd_pop          (cmd_pop),
    .cmd              (cmd)
  );

  // execution and result queue
  fcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_status       = res.status;
  assign out_assigned_id  = res.assigned_id;
  assign out_check_passed = res.check_passed;
  assign out_failed_flag  = res.failed_flag;
  assign out_call_count   = res.call_count;
  assign out_last_ticks   = res.last_ticks;
  assign out_max_ticks    = res.max_ticks;
  assign out_balance      = res.balance;

endmodule

// ----- rtl/fcm_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcm_front
// Accepts requests, checks the id range and buffers them for the back end.
// ---------------------------------------------------------------------------
module fcm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [fcm_pkg::OP_W-1:0]   in_opcode,
  input  logic [fcm_pkg::ID_W-1:0]   in_checkpoint_id,
  input  logic [fcm_pkg::SIG_W-1:0]  in_signature,
  input  logic [fcm_pkg::TS_W-1:0]   in_timestamp,
  output logic                       cmd_valid,
  input  logic                       cmd_pop,
  output fcm_pkg::cmd_t              cmd
);
  import fcm_pkg::*;

  cmd_t                q_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_push, do_pop;
  cmd_t                in_cmd;

  // classify the incoming request
  always_comb begin
    in_cmd.op       = in_opcode;
    in_cmd.id       = in_checkpoint_id;
    in_cmd.in_range = (32'(in_checkpoint_id) < NUM_SLOTS);
    in_cmd.sig      = in_signature;
    in_cmd.ts       = in_timestamp;
  end

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ----- rtl/fcm_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcm_back
// Executes requests against the slot tables and queues the results.
// ---------------------------------------------------------------------------
module fcm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  fcm_pkg::cmd_t cmd,
  input  logic          pop,
  output logic          empty,
  output fcm_pkg::res_t res
);
  import fcm_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;

  // slot tables
  logic [SIG_W-1:0]    sig_tab_r   [NUM_SLOTS];
  logic [TS_W-1:0]     start_tab_r [NUM_SLOTS];
  logic [TS_W-1:0]     last_tab_r  [NUM_SLOTS];
  logic [TS_W-1:0]     max_tab_r   [NUM_SLOTS];
  logic [CNT_W-1:0]    cnt_tab_r   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;

  // global state
  logic [SIG_W-1:0]    acc_r, acc_nxt;
  logic [SLOT_CW-1:0]  used_r, used_nxt;
  logic                fail_r, fail_nxt;

  // request in flight and its table reads
  cmd_t                cur_r;
  logic [SLOT_AW-1:0]  cur_slot;
  logic [SIG_W-1:0]    rd_sig_r;
  logic [TS_W-1:0]     rd_start_r;
  logic [TS_W-1:0]     rd_last_r;
  logic [TS_W-1:0]     rd_max_r;
  logic [CNT_W-1:0]    rd_cnt_r;
  logic                rd_valid_r;
  logic [TS_W-1:0]     diff_r;
  logic [CNT_W-1:0]    cnt_inc_r;

  // commit controls
  logic                commit;
  logic                wr_reg, wr_entry, wr_exit;
  logic [SLOT_AW-1:0]  wr_slot;
  logic [TS_W-1:0]     new_max;
  res_t                res_new;

  // result queue
  res_t                rq_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] rq_wr_r, rq_wr_nxt;
  logic [QUEUE_AW-1:0] rq_rd_r, rq_rd_nxt;
  logic [QUEUE_CW-1:0] rq_count_r, rq_count_nxt;
  logic                rq_full, rq_pop;

  assign cur_slot = SLOT_AW'(cur_r.id);
  assign rq_full  = (rq_count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (rq_count_r == '0);
  assign res      = rq_r[rq_rd_r];
  assign rq_pop   = pop && !empty;
  assign commit   = (state_r == ST_DONE);
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid && !rq_full;

  // sequencer: take, read tables, compute, commit
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // operation result and state updates at commit
  always_comb begin
    res_new  = '0;
    acc_nxt  = acc_r;
    used_nxt = used_r;
    fail_nxt = fail_r;
    wr_reg   = 1'b0;
    wr_entry = 1'b0;
    wr_exit  = 1'b0;
    new_max  = (diff_r > rd_max_r) ? diff_r : rd_max_r;
    unique case (cur_r.op)
      OP_REGISTER: begin
        if (used_r == SLOT_CW'(NUM_SLOTS)) begin
          res_new.status = STAT_FULL;
        end else begin
          wr_reg              = 1'b1;
          used_nxt            = SLOT_CW'(used_r + 1'b1);
          res_new.assigned_id = ID_W'(used_r);
        end
      end
      OP_ENTRY: begin
        if (!rd_valid_r) begin
          res_new.status = STAT_UNREG;
        end else begin
          wr_entry           = 1'b1;
          acc_nxt            = acc_r + rd_sig_r;
          res_new.call_count = rd_cnt_r;
          res_new.last_ticks = rd_last_r;
          res_new.max_ticks  = rd_max_r;
        end
      end
      OP_EXIT: begin
        if (!rd_valid_r) begin
          res_new.status = STAT_UNREG;
        end else begin
          wr_exit            = 1'b1;
          acc_nxt            = acc_r - rd_sig_r;
          res_new.call_count = cnt_inc_r;
          res_new.last_ticks = diff_r;
          res_new.max_ticks  = new_max;
        end
      end
      OP_CHECK: begin
        if (acc_r == '0) begin
          fail_nxt             = 1'b0;
          res_new.check_passed = 1'b1;
        end else begin
          fail_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    res_new.failed_flag = fail_nxt;
    res_new.balance     = acc_nxt;
  end

  assign wr_slot = wr_reg ? SLOT_AW'(used_r) : cur_slot;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= '0;
      used_r  <= '0;
      fail_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        acc_r  <= acc_nxt;
        used_r <= used_nxt;
        fail_r <= fail_nxt;
        if (wr_reg) valid_r[wr_slot] <= 1'b1;
      end
    end
  end

  // request capture, table reads and elapsed time
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
    if (state_r == ST_READ) begin
      rd_sig_r   <= sig_tab_r[cur_slot];
      rd_start_r <= start_tab_r[cur_slot];
      rd_last_r  <= last_tab_r[cur_slot];
      rd_max_r   <= max_tab_r[cur_slot];
      rd_cnt_r   <= cnt_tab_r[cur_slot];
      rd_valid_r <= cur_r.in_range && valid_r[cur_slot];
    end
    if (state_r == ST_CALC) begin
      diff_r    <= cur_r.ts - rd_start_r;
      cnt_inc_r <= CNT_W'(rd_cnt_r + 1'b1);
    end
  end

  // slot table writes
  always_ff @(posedge clk) begin
    if (commit) begin
      if (wr_reg) begin
        sig_tab_r[wr_slot]   <= cur_r.sig;
        start_tab_r[wr_slot] <= '0;
        last_tab_r[wr_slot]  <= '0;
        max_tab_r[wr_slot]   <= '0;
        cnt_tab_r[wr_slot]   <= '0;
      end else if (wr_entry) begin
        start_tab_r[wr_slot] <= cur_r.ts;
      end else if (wr_exit) begin
        last_tab_r[wr_slot] <= diff_r;
        max_tab_r[wr_slot]  <= new_max;
        cnt_tab_r[wr_slot]  <= cnt_inc_r;
      end
    end
  end

  // result queue bookkeeping
  always_comb begin
    rq_wr_nxt    = rq_wr_r;
    rq_rd_nxt    = rq_rd_r;
    rq_count_nxt = rq_count_r;
    if (commit) begin
      rq_wr_nxt = (rq_wr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rq_wr_r + 1'b1;
    end
    if (rq_pop) begin
      rq_rd_nxt = (rq_rd_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rq_rd_r + 1'b1;
    end
    if (commit && !rq_pop) begin
      rq_count_nxt = rq_count_r + 1'b1;
    end else if (rq_pop && !commit) begin
      rq_count_nxt = rq_count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r    <= '0;
      rq_rd_r    <= '0;
      rq_count_r <= '0;
    end else begin
      rq_wr_r    <= rq_wr_nxt;
      rq_rd_r    <= rq_rd_nxt;
      rq_count_r <= rq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rq_r[rq_wr_r] <= res_new;
    end
  end

endmodule

// ----- rtl/fcm_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcm_checker
// Port level checks of the checkpoint monitor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [fcm_pkg::STAT_W-1:0] out_status,
  input logic [fcm_pkg::ID_W-1:0]   out_assigned_id,
  input logic                       out_check_passed,
  input logic                       out_failed_flag,
  input logic [fcm_pkg::SIG_W-1:0]  out_balance
);
  import fcm_pkg::*;

  logic                    res_err;   // result shown with an error status
  logic                    res_pass;  // result shown reporting a passed check
  logic                    res_wait;  // result shown and not taken
  logic                    pass_ok;
  logic [STAT_W+SIG_W-1:0] res_sig;

  // shorthand terms on the result ports
  assign res_err  = !empty && (out_status != STAT_OK);
  assign res_pass = !empty && out_check_passed;
  assign res_wait = !empty && !pop;
  assign pass_ok  = !out_failed_flag && (out_balance == '0) && (out_status == STAT_OK);
  assign res_sig  = {out_status, out_balance};

  // both queues come out of reset empty
  `FCM_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> empty && !full, "reset left queues busy")

  // a slot id is only reported by a successful register
  `FCM_ASSERT(a_id_only_ok, clk, rst_n, res_err |-> out_assigned_id == '0, "slot id on error")

  // a passed check means a zero accumulator and a clear failure flag
  `FCM_ASSERT(a_pass_consistent, clk, rst_n, res_pass |-> pass_ok, "inconsistent check result")

  // a result not taken stays on the ports
  `FCM_ASSERT(a_res_holds, clk, rst_n, res_wait |=> !empty && $stable(res_sig), "result changed")

endmodule

bind flow_checkpoint_monitor fcm_checker u_fcm_checker (.*);
